@@ hw/rtl/dxt_pkg.sv @@
// ----------------------------------------------------------------------------
// dxt_pkg
// Shared types, constants and helpers for the DXT block compressor.
// ----------------------------------------------------------------------------
package dxt_pkg;

	localparam logic [14:0] RECIP3  = 15'((1 << 16) / 3 + 1);
	localparam logic [13:0] RECIP7  = 14'((1 << 16) / 7 + 1);
	localparam logic [12:0] RECIP14 = 13'((1 << 16) / 14 + 1);
	localparam logic [7:0]  MASK5   = 8'hF8;
	localparam logic [7:0]  MASK6   = 8'hFC;
	localparam int unsigned BOX_SHRINK = 4;

	localparam logic [2:0] SCALE_HI [3] = '{3'd6, 3'd5, 3'd4};
	localparam logic [2:0] SCALE_LO [3] = '{3'd1, 3'd2, 3'd3};

	// commands from the controller to the datapath
	typedef struct packed {
		logic       load_row;
		logic [1:0] row;
		logic       inset;
		logic       pal;
		logic       thr;
		logic       idx;
		logic [3:0] ptr;
		logic       sel_alpha;
	} cmd_t;

	typedef struct packed {
		logic mode;
	} stat_t;

	function automatic logic [7:0] sat8(input logic [9:0] v);
		sat8 = (v > 10'd255) ? 8'hFF : v[7:0];
	endfunction

	function automatic logic [7:0] absdiff(input logic [7:0] a, input logic [7:0] b);
		absdiff = (a > b) ? a - b : b - a;
	endfunction

endpackage

@@ hw/rtl/dxt_datapath.sv @@
// ----------------------------------------------------------------------------
// dxt_datapath
// Pixel store, bounding box, palette, alpha thresholds and index shifters.
// ----------------------------------------------------------------------------
module dxt_datapath (
	input  logic           clk,
	input  logic           arst_n,
	input  dxt_pkg::cmd_t  cmd,
	input  logic [31:0]    pixel_a,
	input  logic [31:0]    pixel_b,
	input  logic [31:0]    pixel_c,
	input  logic [31:0]    pixel_d,
	input  logic           cfg_wr_en,
	input  logic           cfg_wr_data,
	output dxt_pkg::stat_t stat,
	output logic [63:0]    block_word
);
	import dxt_pkg::*;

	logic [31:0] px [4];
	logic [31:0] store_q [16];
	logic [7:0]  min_q [4];
	logic [7:0]  max_q [4];
	logic [7:0]  rmin [4];
	logic [7:0]  rmax [4];
	logic [7:0]  lo_q [4];
	logic [7:0]  hi_q [4];
	logic [7:0]  pal_q [4][3];
	logic [7:0]  pal_d [4][3];
	logic [7:0]  mid_q;
	logic [8:0]  aq_q [6];
	logic [7:0]  mid_d;
	logic [8:0]  aq_d [6];
	logic [7:0]  th_q [7];
	logic [31:0] cbits_q;
	logic [47:0] abits_q;
	logic        mode_q;
	logic        blk_mode_q;
	logic [31:0] cur;
	logic [1:0]  cidx;
	logic [2:0]  aidx;
	logic [15:0] max565;
	logic [15:0] min565;

	assign px[0] = pixel_a;
	assign px[1] = pixel_b;
	assign px[2] = pixel_c;
	assign px[3] = pixel_d;

	// running box over the incoming row
	always_comb begin
		for (int c = 0; c < 4; c++) begin
			rmin[c] = min_q[c];
			rmax[c] = max_q[c];
			for (int i = 0; i < 4; i++) begin
				if (px[i][8*c +: 8] < rmin[c]) rmin[c] = px[i][8*c +: 8];
				if (px[i][8*c +: 8] > rmax[c]) rmax[c] = px[i][8*c +: 8];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < 4; c++) begin
				min_q[c] <= 8'hFF;
				max_q[c] <= 8'h00;
			end
			mode_q     <= 1'b0;
			blk_mode_q <= 1'b0;
		end else begin
			if (cfg_wr_en) mode_q <= cfg_wr_data;
			if (cmd.load_row) begin
				min_q <= rmin;
				max_q <= rmax;
			end else if (cmd.inset) begin
				for (int c = 0; c < 4; c++) begin
					min_q[c] <= 8'hFF;
					max_q[c] <= 8'h00;
				end
				blk_mode_q <= mode_q;
			end
		end
	end

	assign stat.mode = blk_mode_q;

	// palette and alpha quotients
	always_comb begin
		logic [7:0]  h;
		logic [7:0]  l;
		logic [9:0]  s2;
		logic [9:0]  s3;
		logic [24:0] p2;
		logic [24:0] p3;
		logic [10:0] sa;
		logic [10:0] sb;
		logic [24:0] qa;
		logic [24:0] qb;
		logic [20:0] pm;
		for (int c = 0; c < 3; c++) begin
			h = hi_q[c] & ((c == 1) ? MASK6 : MASK5);
			l = lo_q[c] & ((c == 1) ? MASK6 : MASK5);
			pal_d[0][c] = (c == 1) ? (h | (h >> 6)) : (h | (h >> 5));
			pal_d[1][c] = (c == 1) ? (l | (l >> 6)) : (l | (l >> 5));
			s2 = {1'b0, pal_d[0][c], 1'b0} + {2'b00, pal_d[1][c]};
			s3 = {2'b00, pal_d[0][c]} + {1'b0, pal_d[1][c], 1'b0};
			p2 = 25'(s2) * 25'(RECIP3);
			p3 = 25'(s3) * 25'(RECIP3);
			pal_d[2][c] = sat8(p2[25-1:16] > 9'd255 ? 10'h3FF : {1'b0, p2[24:16]});
			pal_d[3][c] = sat8(p3[25-1:16] > 9'd255 ? 10'h3FF : {1'b0, p3[24:16]});
		end
		pm = 21'(hi_q[3] - lo_q[3]) * 21'(RECIP14);
		mid_d = pm[23-3:16] > 5'd0 ? 8'(pm[20:16]) : 8'd0;
		for (int k = 0; k < 3; k++) begin
			sa = 11'(SCALE_HI[k]) * 11'(hi_q[3]) + 11'(SCALE_LO[k]) * 11'(lo_q[3]);
			sb = 11'(SCALE_LO[k]) * 11'(hi_q[3]) + 11'(SCALE_HI[k]) * 11'(lo_q[3]);
			qa = 25'(sa) * 25'(RECIP7);
			qb = 25'(sb) * 25'(RECIP7);
			aq_d[k]     = qa[24:16];
			aq_d[3 + k] = qb[24:16];
		end
	end

	// per-pixel index selection
	always_comb begin
		logic [9:0] d [4];
		logic       b0, b1, b2, b3, b4;
		logic [2:0] cnt;
		cur = store_q[cmd.ptr];
		for (int k = 0; k < 4; k++) begin
			d[k] = 10'(absdiff(cur[7:0], pal_q[k][0])) + 10'(absdiff(cur[15:8], pal_q[k][1]))
				+ 10'(absdiff(cur[23:16], pal_q[k][2]));
		end
		b0 = d[0] > d[3];
		b1 = d[1] > d[2];
		b2 = d[0] > d[2];
		b3 = d[1] > d[3];
		b4 = d[2] > d[3];
		cidx = {(b2 && b1) || (b3 && b0), b4 && b0};
		cnt = 3'd1;
		for (int k = 0; k < 7; k++) begin
			if (cur[31:24] <= th_q[k]) cnt = cnt + 3'd1;
		end
		aidx = (cnt < 3'd2) ? (cnt ^ 3'd1) : cnt;
	end

	always_ff @(posedge clk) begin
		if (cmd.load_row) begin
			for (int i = 0; i < 4; i++) store_q[{cmd.row, 2'(i)}] <= px[i];
		end
		if (cmd.inset) begin
			for (int c = 0; c < 4; c++) begin
				lo_q[c] <= min_q[c] + ((max_q[c] - min_q[c]) >> BOX_SHRINK);
				hi_q[c] <= max_q[c] - ((max_q[c] - min_q[c]) >> BOX_SHRINK);
			end
		end
		if (cmd.pal) begin
			pal_q <= pal_d;
			mid_q <= mid_d;
			aq_q  <= aq_d;
		end
		if (cmd.thr) begin
			th_q[0] <= sat8(10'(lo_q[3]) + 10'(mid_q));
			for (int k = 0; k < 6; k++) th_q[1 + k] <= sat8(10'(aq_q[k]) + 10'(mid_q));
		end
		if (cmd.idx) begin
			cbits_q <= {cidx, cbits_q[31:2]};
			abits_q <= {aidx, abits_q[47:3]};
		end
	end

	assign max565 = {hi_q[0][7:3], hi_q[1][7:2], hi_q[2][7:3]};
	assign min565 = {lo_q[0][7:3], lo_q[1][7:2], lo_q[2][7:3]};
	assign block_word = cmd.sel_alpha ? {abits_q, lo_q[3], hi_q[3]}
	                                  : {cbits_q, min565, max565};

endmodule

@@ hw/rtl/dxt_ctrl.sv @@
// ----------------------------------------------------------------------------
// dxt_ctrl
// Sequencer: row loading, setup steps, index sweep and word hand-off.
// ----------------------------------------------------------------------------
module dxt_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	output logic           out_valid,
	input  logic           out_stall,
	output logic           block_last,
	input  dxt_pkg::stat_t stat,
	output dxt_pkg::cmd_t  cmd
);
	import dxt_pkg::*;

	localparam logic [2:0] S_LOAD  = 3'd0;
	localparam logic [2:0] S_INSET = 3'd1;
	localparam logic [2:0] S_PAL   = 3'd2;
	localparam logic [2:0] S_THR   = 3'd3;
	localparam logic [2:0] S_IDX   = 3'd4;
	localparam logic [2:0] S_ALPHA = 3'd5;
	localparam logic [2:0] S_COLOR = 3'd6;

	logic [2:0] state_q;
	logic [1:0] row_q;
	logic [3:0] ptr_q;

	assign in_stall   = (state_q != S_LOAD);
	assign out_valid  = (state_q == S_ALPHA) || (state_q == S_COLOR);
	assign block_last = (state_q == S_COLOR);

	always_comb begin
		cmd           = '0;
		cmd.row       = row_q;
		cmd.ptr       = ptr_q;
		cmd.load_row  = (state_q == S_LOAD) && in_valid;
		cmd.inset     = (state_q == S_INSET);
		cmd.pal       = (state_q == S_PAL);
		cmd.thr       = (state_q == S_THR);
		cmd.idx       = (state_q == S_IDX);
		cmd.sel_alpha = (state_q == S_ALPHA);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
			row_q   <= 2'd0;
			ptr_q   <= 4'd0;
		end else begin
			case (state_q)
				S_LOAD: begin
					if (in_valid) begin
						row_q <= row_q + 2'd1;
						if (row_q == 2'd3) state_q <= S_INSET;
					end
				end
				S_INSET: state_q <= S_PAL;
				S_PAL:   state_q <= S_THR;
				S_THR: begin
					ptr_q   <= 4'd0;
					state_q <= S_IDX;
				end
				S_IDX: begin
					ptr_q <= ptr_q + 4'd1;
					if (ptr_q == 4'd15) state_q <= stat.mode ? S_ALPHA : S_COLOR;
				end
				S_ALPHA: if (!out_stall) state_q <= S_COLOR;
				S_COLOR: if (!out_stall) state_q <= S_LOAD;
				default: state_q <= S_LOAD;
			endcase
		end
	end

endmodule

@@ hw/rtl/dxt_block_compressor.sv @@
// Before the first word is offered, the four rows are loaded, then the inset,
// palette and threshold setup steps run, then the pixels are swept one pixel
// a cycle through the shared index unit. Rows load one a cycle while in_valid
// is high, and input is stalled while a block is processed or emitted.
// Reset (arst_n low, asynchronous): row count, box min/max, mode and the
// sequencer clear; the pixel store and index registers are left as they are.
// ----------------------------------------------------------------------------
// dxt_block_compressor
// DXT1 / DXT5 encoder for one 4x4 RGBA block received as four rows.
// ----------------------------------------------------------------------------
module dxt_block_compressor (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] pixel_a,
	input  logic [31:0] pixel_b,
	input  logic [31:0] pixel_c,
	input  logic [31:0] pixel_d,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] block_word,
	output logic        block_last,
	input  logic        cfg_wr_en,
	input  logic        cfg_wr_data
);
	import dxt_pkg::*;

	// commands flow controller -> datapath; block mode flows back
	cmd_t  cmd;
	stat_t stat;

	// Controller: hold input stalled outside row loading, advance through
	// inset, palette and threshold setup, sweep the sixteen pixels, then
	// offer the alpha item (DXT5 only) and the colour item.
	dxt_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.block_last (block_last),
		.stat       (stat),
		.cmd        (cmd)
	);

	// Datapath: store pixels, track the box, build palette and thresholds,
	// shift in indices and present the selected output word from registers.
	dxt_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.pixel_a     (pixel_a),
		.pixel_b     (pixel_b),
		.pixel_c     (pixel_c),
		.pixel_d     (pixel_d),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.stat        (stat),
		.block_word  (block_word)
	);

endmodule

@@ hw/rtl/dxt_chk.sv @@
// ----------------------------------------------------------------------------
// dxt_chk
// Port-level checks for the block compressor, bound to the top level.
// ----------------------------------------------------------------------------
module dxt_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [63:0] block_word,
	input logic        block_last
);

	// input is never taken while a word is on offer
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall) else $error("input open during output");

	// alpha word is always followed by the colour word
	a_pair: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !block_last |=> out_valid && block_last)
		else $error("alpha word not followed by colour word");

	// after the final word the block reopens for rows
	a_reopen: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && block_last |=> !in_stall && !out_valid)
		else $error("no return to loading after block");

	// stalled word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(block_word) && $stable(block_last))
		else $error("stalled word changed");

endmodule

bind dxt_block_compressor dxt_chk u_dxt_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.block_word (block_word),
	.block_last (block_last)
);
